### rtl/sem_pkg.sv
package sem_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = 12;
	localparam int PIX_W      = 8;
	localparam int SLOTS      = 4;
	localparam int SLOT_W     = 2;
	localparam int OWED_W     = $clog2(MAX_WIDTH + 2);
	localparam int WCFG_W     = 11;
	localparam int CFG_W      = 12;
	localparam int CFG_IDX_W  = 1;
	localparam int OUTQ_DEPTH = 3;
	localparam int LVL_W      = 2;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	typedef logic [PIX_W-1:0]  pix_t;
	typedef logic [COL_W-1:0]  col_t;
	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [SLOTS-1:0][PIX_W-1:0] bank_t;

	localparam col_t WIDTH_M1_RESET  = COL_W'((640 > MAX_WIDTH ? MAX_WIDTH : 640) - 1);
	localparam row_t HEIGHT_M1_RESET = ROW_W'(479);

	// line store write issued with the accepted pixel
	typedef struct packed {
		logic  en;
		slot_t slot;
		col_t  col;
		pix_t  data;
	} wr_req_t;

	// column read issued with the accepted item, and what stage 1 does with it
	typedef struct packed {
		logic  emit;
		logic  clamp;
		logic  load0;
		col_t  col;
		slot_t su;
		slot_t sm;
		slot_t sd;
		logic  frame_end;
	} rd_req_t;

	typedef struct packed {
		pix_t t;
		pix_t m;
		pix_t b;
	} column_t;

	typedef struct packed {
		pix_t mag;
		logic last;
	} result_t;

endpackage

### rtl/sem_ram.sv
module sem_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/sem_ctrl.sv
module sem_ctrl import sem_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 accept,
	input  logic                 command,
	input  pix_t                 pixel,
	output wr_req_t              wr,
	output rd_req_t              rd
);

	col_t              width_m1_q;
	row_t              height_m1_q;
	col_t              in_col_q;
	row_t              in_row_q;
	slot_t             in_slot_q;
	col_t              out_col_q;
	row_t              out_row_q;
	slot_t             out_slot_q;
	logic [OWED_W-1:0] owed_q;

	logic [WCFG_W-1:0] wcfg;
	row_t              hcfg;
	col_t              width_m1_d;
	row_t              height_m1_d;
	logic              is_pixel;
	logic              is_drain;
	logic              emit;
	logic              out_last_col;
	logic              out_last_row;
	row_t              nxt_row;
	slot_t             nxt_slot;

	function automatic slot_t up_slot(row_t r, slot_t s);
		return (r != '0) ? s - SLOT_W'(1) : s;
	endfunction

	function automatic slot_t down_slot(row_t r, slot_t s, row_t hm1);
		return (r != hm1) ? s + SLOT_W'(1) : s;
	endfunction

	always_comb begin
		wcfg = cfg_data[WCFG_W-1:0];
		hcfg = cfg_data[ROW_W-1:0];
		if (32'(wcfg) < 32'd3) begin
			width_m1_d = COL_W'(2);
		end else if (32'(wcfg) > 32'(MAX_WIDTH)) begin
			width_m1_d = COL_W'(MAX_WIDTH - 1);
		end else begin
			width_m1_d = COL_W'(wcfg - WCFG_W'(1));
		end
		if (hcfg < ROW_W'(3)) begin
			height_m1_d = ROW_W'(2);
		end else begin
			height_m1_d = hcfg - ROW_W'(1);
		end
	end

	always_comb begin
		is_pixel     = accept && (command == CMD_PIXEL);
		is_drain     = accept && (command == CMD_DRAIN);
		out_last_col = (out_col_q == width_m1_q);
		out_last_row = (out_row_q == height_m1_q);
		nxt_row      = out_last_row ? '0 : out_row_q + ROW_W'(1);
		nxt_slot     = out_slot_q + SLOT_W'(1);
		emit = (is_pixel && (owed_q > OWED_W'(width_m1_q) + OWED_W'(1)))
			|| (is_drain && (in_col_q == '0) && (in_row_q == '0) && (owed_q != '0));

		wr.en   = is_pixel;
		wr.slot = in_slot_q;
		wr.col  = in_col_q;
		wr.data = pixel;

		// at a row's last output the right column repeats the centre, so the
		// read port fetches column 0 of the next row instead
		rd.emit      = emit;
		rd.clamp     = emit && out_last_col;
		rd.load0     = rd.clamp || (accept && !emit && (out_col_q == '0));
		rd.col       = (out_last_col || !emit) ? '0 : out_col_q + COL_W'(1);
		rd.frame_end = out_last_row && out_last_col;
		if (rd.clamp) begin
			rd.sm = nxt_slot;
			rd.su = up_slot(nxt_row, nxt_slot);
			rd.sd = down_slot(nxt_row, nxt_slot, height_m1_q);
		end else begin
			rd.sm = out_slot_q;
			rd.su = up_slot(out_row_q, out_slot_q);
			rd.sd = down_slot(out_row_q, out_slot_q, height_m1_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_m1_q  <= WIDTH_M1_RESET;
			height_m1_q <= HEIGHT_M1_RESET;
			in_col_q    <= '0;
			in_row_q    <= '0;
			in_slot_q   <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			out_slot_q  <= '0;
			owed_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH: begin
					width_m1_q <= width_m1_d;
				end
				REG_FRAME_HEIGHT: begin
					height_m1_q <= height_m1_d;
				end
				default: ;
			endcase
			// restart the stream
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
			owed_q     <= '0;
		end else if (accept) begin
			if (is_pixel) begin
				if (in_col_q == width_m1_q) begin
					in_col_q  <= '0;
					in_slot_q <= in_slot_q + SLOT_W'(1);
					in_row_q  <= (in_row_q == height_m1_q) ? '0 : in_row_q + ROW_W'(1);
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
			end
			if (emit) begin
				if (out_last_col) begin
					out_col_q  <= '0;
					out_slot_q <= nxt_slot;
					out_row_q  <= nxt_row;
				end else begin
					out_col_q <= out_col_q + COL_W'(1);
				end
			end
			if (is_pixel && !emit) begin
				owed_q <= owed_q + OWED_W'(1);
			end else if (is_drain && emit) begin
				owed_q <= owed_q - OWED_W'(1);
			end
		end
	end

	a_owed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		owed_q <= OWED_W'(width_m1_q) + OWED_W'(2))
		else $error("output backlog exceeds one row plus one");

	a_cols_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		(in_col_q <= width_m1_q) && (out_col_q <= width_m1_q))
		else $error("column position beyond the row");

endmodule

### rtl/sem_win.sv
module sem_win import sem_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  rd_req_t rd,
	input  wr_req_t wr,
	input  bank_t   bank,
	output logic    busy,
	output logic    push,
	output result_t res
);

	rd_req_t rd_s1;
	wr_req_t wr_s1;
	column_t p_q;
	column_t q_q;

	column_t         fresh;
	column_t         right;
	logic [PIX_W+1:0] sum_r;
	logic [PIX_W+1:0] sum_l;
	logic [PIX_W+1:0] sum_b;
	logic [PIX_W+1:0] sum_t;
	logic [PIX_W+1:0] abs_x;
	logic [PIX_W+1:0] abs_y;
	logic [PIX_W+2:0] total;

	// the write issued with the read lands in the same edge; take it over
	function automatic pix_t pick(slot_t s, bank_t b, wr_req_t w, col_t c);
		return (w.en && (w.slot == s) && (w.col == c)) ? w.data : b[s];
	endfunction

	function automatic logic [PIX_W+1:0] tap3(pix_t a, pix_t m, pix_t z);
		return {2'b00, a} + {1'b0, m, 1'b0} + {2'b00, z};
	endfunction

	function automatic logic [PIX_W+1:0] absdiff(logic [PIX_W+1:0] a, logic [PIX_W+1:0] z);
		return (a >= z) ? a - z : z - a;
	endfunction

	always_comb begin
		fresh.t = pick(rd_s1.su, bank, wr_s1, rd_s1.col);
		fresh.m = pick(rd_s1.sm, bank, wr_s1, rd_s1.col);
		fresh.b = pick(rd_s1.sd, bank, wr_s1, rd_s1.col);
		right   = rd_s1.clamp ? q_q : fresh;

		sum_r = tap3(right.t, right.m, right.b);
		sum_l = tap3(p_q.t, p_q.m, p_q.b);
		sum_b = tap3(p_q.b, q_q.b, right.b);
		sum_t = tap3(p_q.t, q_q.t, right.t);
		abs_x = absdiff(sum_r, sum_l);
		abs_y = absdiff(sum_b, sum_t);
		total = {1'b0, abs_x} + {1'b0, abs_y};

		busy     = rd_s1.emit;
		push     = rd_s1.emit;
		res.mag  = total[PIX_W+2:3];
		res.last = rd_s1.frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= '0;
			wr_s1 <= '0;
		end else begin
			rd_s1 <= rd;
			wr_s1 <= wr;
		end
	end

	// hold columns c-1 and c; column 0 loads into both
	always_ff @(posedge clk) begin
		if (rd_s1.load0) begin
			p_q <= fresh;
			q_q <= fresh;
		end else if (rd_s1.emit) begin
			p_q <= q_q;
			q_q <= fresh;
		end
	end

	a_clamp_reload: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1.clamp |-> (rd_s1.emit && rd_s1.load0 && (rd_s1.col == '0)))
		else $error("row end without a column 0 fetch");

endmodule

### rtl/sem_outq.sv
module sem_outq import sem_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  result_t          din,
	input  logic             ready,
	output logic             valid,
	output result_t          dout,
	output logic [LVL_W-1:0] level
);

	result_t          buf_q [OUTQ_DEPTH];
	logic [LVL_W-1:0] wr_ptr_q;
	logic [LVL_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;
	logic             pop;

	function automatic logic [LVL_W-1:0] bump(logic [LVL_W-1:0] p);
		return (p == LVL_W'(OUTQ_DEPTH - 1)) ? '0 : p + LVL_W'(1);
	endfunction

	always_comb begin
		valid = (level_q != '0);
		dout  = buf_q[rd_ptr_q];
		level = level_q;
		pop   = valid && ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				level_q <= level_q + LVL_W'(1);
			end else if (pop && !push) begin
				level_q <= level_q - LVL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= din;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (level_q != LVL_W'(OUTQ_DEPTH)))
		else $error("result pushed into a full queue");

endmodule

### rtl/sobel_edge_magnitude.sv
// channel   | dir | beat contents                                   | handshake
// s_axis    | in  | tdata[7:0] pixel, tuser[0] command (1 = drain)  | tvalid/tready
// m_axis    | out | tdata[7:0] magnitude, tlast frame end           | tvalid/tready
// cfg       | in  | cfg_index 0 width, 1 height; cfg_data[11:0]     | cfg_we, no wait
//
// One item per cycle while s_axis_tready is high; results are registered, then queued.
// The four row RAMs each give one column read per item: the centre column's
// right neighbour, or column 0 of the next row at a row's end.
// s_axis_tready drops only when the three-beat result queue and the beat in
// flight together fill it. A config write restarts the stream.
// Reset sets 640x480 and clears positions; the row RAMs are not cleared.
module sobel_edge_magnitude import sem_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,   // [7:0] pixel
	input  logic [0:0]           s_axis_tuser,   // [0] command
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [7:0]           m_axis_tdata,   // [7:0] magnitude
	output logic                 m_axis_tlast,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	wr_req_t          wr;
	rd_req_t          rd;
	bank_t            bank;
	logic             accept;
	logic             busy;
	logic             push;
	result_t          res;
	result_t          dout;
	logic [LVL_W-1:0] level;
	logic [LVL_W:0]   pending;

	always_comb begin
		pending       = {1'b0, level} + {{LVL_W{1'b0}}, busy};
		s_axis_tready = (pending < (LVL_W + 1)'(OUTQ_DEPTH));
		accept        = s_axis_tvalid && s_axis_tready;
		m_axis_tdata  = dout.mag;
		m_axis_tlast  = dout.last;
	end

	sem_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.command   (s_axis_tuser[0]),
		.pixel     (s_axis_tdata),
		.wr        (wr),
		.rd        (rd)
	);

	for (genvar g = 0; g < SLOTS; g++) begin : g_row
		sem_ram #(
			.WIDTH (PIX_W),
			.DEPTH (MAX_WIDTH)
		) u_ram (
			.clk   (clk),
			.we    (wr.en && (wr.slot == SLOT_W'(g))),
			.waddr (wr.col),
			.wdata (wr.data),
			.raddr (rd.col),
			.rdata (bank[g])
		);
	end

	sem_win u_win (
		.clk    (clk),
		.arst_n (arst_n),
		.rd     (rd),
		.wr     (wr),
		.bank   (bank),
		.busy   (busy),
		.push   (push),
		.res    (res)
	);

	sem_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (res),
		.ready  (m_axis_tready),
		.valid  (m_axis_tvalid),
		.dout   (dout),
		.level  (level)
	);

endmodule
